### rtl/core/rftp_pkg.sv
// ============================================================================
// rftp_pkg: shared constants and types for the rolling frame-time percentile
// Window geometry, history limit, derived widths and register indexes.
// ============================================================================
package rftp_pkg;

    localparam int WINDOW        = 64;
    localparam int HISTORY_LIMIT = 65536;

    localparam int TIME_W   = 24;
    localparam int PCT_W    = 7;
    localparam int WARMUP_W = 4;

    localparam int ADDR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int FRAMES_W = $clog2(HISTORY_LIMIT + 1);
    localparam int SUM_W    = TIME_W + $clog2(HISTORY_LIMIT);
    localparam int DIVCNT_W = $clog2(SUM_W + 1);

    // rank = ceil(p * n / 100) via reciprocal multiply
    localparam int RANK_W     = PCT_W + FILL_W + 1;
    localparam int RECIP_SH   = 24;
    localparam int RECIP      = ((1 << RECIP_SH) + 99) / 100;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int RANK_BIAS  = 99;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PCT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENTILE = 1'd1;

    localparam logic [WARMUP_W-1:0] WARMUP_RESET  = 4'd5;
    localparam logic [PCT_W-1:0]    PCT_RESET     = 7'd95;

    typedef logic [TIME_W-1:0] time_t;

endpackage

### rtl/core/rolling_frame_time_percentile.sv
// ============================================================================
// rolling_frame_time_percentile: rolling window percentile and mean
// of frame durations in microseconds.
//
// Input channel (in_valid/in_ready, frame_time_us): one word per finished
// frame. After warmup_frames frames, each duration enters a 64-entry ring
// and, up to the history limit, a running sum.
// Output channel (out_valid/out_ready): one word per input word with the
// selected percentile of the window, the truncated mean and the fill.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
// warmup_frames, index 1 is percentile; always ready.
// One word at a time. The result registers after the input word once the
// selection has tried k <= n candidates for fill n: it scans the window
// memory through its single read port once per candidate. After warm-up
// the mean divider runs alongside and holds the result until the mean is done;
// an empty window skips the search. The next word is taken in the cycle
// after the result registers, even while the receiver stalls; a stalled
// receiver holds the following result until the register frees.
// Reset empties the window and sum and restores warm-up 5 and
// percentile 95; the window memory needs no clearing.
// ============================================================================
module rolling_frame_time_percentile
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rftp_pkg::TIME_W-1:0]      frame_time_us,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rftp_pkg::TIME_W-1:0]      percentile_time_us,
    output logic [rftp_pkg::TIME_W-1:0]      mean_time_us,
    output logic [rftp_pkg::FILL_W-1:0]      window_fill,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rftp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rftp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RMUL  = 3'd1;
    localparam logic [2:0] S_RDIV  = 3'd2;
    localparam logic [2:0] S_RCLMP = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_CHECK = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam int AW = rftp_pkg::ADDR_W;
    localparam int FW = rftp_pkg::FILL_W;
    localparam int NW = rftp_pkg::FRAMES_W;
    localparam int SW = rftp_pkg::SUM_W;
    localparam int RW = rftp_pkg::RANK_W;
    localparam int PW = RW + rftp_pkg::RECIP_W;

    rftp_pkg::time_t                 mem [rftp_pkg::WINDOW];
    rftp_pkg::time_t                 rd_data_reg;
    logic [AW-1:0]                   rd_addr;
    logic                            mem_we;

    logic [2:0]                      state_reg, state_next;
    logic [rftp_pkg::WARMUP_W-1:0]   warmup_reg;
    logic [rftp_pkg::PCT_W-1:0]      pct_reg;
    logic [AW-1:0]                   slot_reg;
    logic [FW-1:0]                   fill_reg;
    logic [NW-1:0]                   frames_reg;
    logic [SW-1:0]                   sum_reg;

    logic [NW-1:0]                   frames_next;
    logic [SW-1:0]                   sum_next;
    logic                            past_next;
    logic [FW-1:0]                   fill_next;

    logic                            in_acc;
    logic                            past_reg;
    logic [FW-1:0]                   n_reg;
    logic [RW-1:0]                   rprod_reg;
    logic [FW:0]                     rq_reg;
    logic [FW-1:0]                   rank_reg;
    logic [AW-1:0]                   cand_reg;
    logic [FW-1:0]                   scan_reg;
    rftp_pkg::time_t                 cval_reg;
    logic [FW-1:0]                   less_reg;
    logic [FW-1:0]                   le_reg;
    rftp_pkg::time_t                 pct_val_reg;
    logic                            found;
    logic                            last_cand;
    logic [PW-1:0]                   rmul;

    logic                            div_busy;
    rftp_pkg::time_t                 div_q;

    logic                            out_valid_reg;
    logic                            out_load;
    rftp_pkg::time_t                 out_pct_reg;
    rftp_pkg::time_t                 out_mean_reg;
    logic [FW-1:0]                   out_fill_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // statistics update for the incoming word
    always_comb
    begin
        frames_next = frames_reg;
        sum_next    = sum_reg;
        if (frames_reg < NW'(rftp_pkg::HISTORY_LIMIT))
        begin
            frames_next = frames_reg + NW'(1);
            if (frames_next > NW'(warmup_reg))
            begin
                sum_next = sum_reg + SW'(frame_time_us);
            end
        end
        past_next = frames_next > NW'(warmup_reg);
        fill_next = fill_reg;
        if (past_next && (fill_reg < FW'(rftp_pkg::WINDOW)))
        begin
            fill_next = fill_reg + FW'(1);
        end
    end

    assign mem_we = in_acc && past_next;

    always_comb
    begin
        case (state_reg)
            S_SCAN:  rd_addr = scan_reg[AW-1:0];
            default: rd_addr = cand_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= frame_time_us;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg <= rftp_pkg::WARMUP_RESET;
            pct_reg    <= rftp_pkg::PCT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rftp_pkg::CFG_WARMUP:     warmup_reg <= cfg_data[rftp_pkg::WARMUP_W-1:0];
                rftp_pkg::CFG_PERCENTILE: pct_reg    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            fill_reg   <= '0;
            frames_reg <= '0;
            sum_reg    <= '0;
        end
        else if (in_acc)
        begin
            frames_reg <= frames_next;
            sum_reg    <= sum_next;
            fill_reg   <= fill_next;
            if (past_next)
            begin
                slot_reg <= (slot_reg == AW'(rftp_pkg::WINDOW - 1))
                          ? '0 : slot_reg + AW'(1);
            end
        end
    end

    rftp_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mem_we),
        .dividend (sum_next),
        .divisor  (frames_next - NW'(warmup_reg)),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // rank search
    assign rmul      = PW'(rprod_reg) * PW'(rftp_pkg::RECIP);
    assign found     = (less_reg < rank_reg) && (rank_reg <= le_reg);
    assign last_cand = (cand_reg == AW'(n_reg - FW'(1)));
    assign out_load  = (state_reg == S_DONE) && !div_busy && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_RMUL;
            S_RMUL:  state_next = (n_reg == '0) ? S_DONE : S_RDIV;
            S_RDIV:  state_next = S_RCLMP;
            S_RCLMP: state_next = S_LOAD;
            S_LOAD:  state_next = S_SCAN;
            S_SCAN:  if (scan_reg == n_reg) state_next = S_CHECK;
            S_CHECK: state_next = found ? S_DONE : S_LOAD;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                n_reg    <= fill_next;
                past_reg <= past_next;
            end
            S_RMUL:
            begin
                rprod_reg   <= RW'(pct_reg) * RW'(n_reg) + RW'(rftp_pkg::RANK_BIAS);
                pct_val_reg <= '0;
            end
            S_RDIV:
            begin
                rq_reg <= rmul[rftp_pkg::RECIP_SH +: FW+1];
            end
            S_RCLMP:
            begin
                if (rq_reg == '0)
                    rank_reg <= FW'(1);
                else if (rq_reg > {1'b0, n_reg})
                    rank_reg <= n_reg;
                else
                    rank_reg <= rq_reg[FW-1:0];
                cand_reg <= '0;
            end
            S_LOAD:
            begin
                scan_reg <= '0;
                less_reg <= '0;
                le_reg   <= '0;
            end
            S_SCAN:
            begin
                scan_reg <= scan_reg + FW'(1);
                if (scan_reg == '0)
                begin
                    cval_reg <= rd_data_reg;
                end
                else
                begin
                    less_reg <= less_reg + FW'(rd_data_reg < cval_reg);
                    le_reg   <= le_reg + FW'(rd_data_reg <= cval_reg);
                end
            end
            S_CHECK:
            begin
                if (found)
                    pct_val_reg <= cval_reg;
                else
                    cand_reg <= cand_reg + AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pct_reg  <= pct_val_reg;
            out_mean_reg <= past_reg ? div_q : '0;
            out_fill_reg <= n_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign percentile_time_us = out_pct_reg;
    assign mean_time_us       = out_mean_reg;
    assign window_fill        = out_fill_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(rftp_pkg::WINDOW))
        else $error("window fill beyond depth");

    a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg <= NW'(rftp_pkg::HISTORY_LIMIT))
        else $error("frame count beyond history limit");

    a_last_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) && last_cand |-> found)
        else $error("rank not found in window");

    a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !div_busy)
        else $error("word accepted while mean divider busy");

    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && !div_busy)
        else $error("result registered before mean ready");

endmodule

### rtl/core/rftp_divider.sv
// ============================================================================
// rftp_divider: restoring divider for the running mean
// One quotient bit per cycle; the quotient saturates to the time width.
// ============================================================================
module rftp_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rftp_pkg::SUM_W-1:0]    dividend,
    input  logic [rftp_pkg::FRAMES_W-1:0] divisor,
    output logic                          busy,
    output rftp_pkg::time_t               quotient
);

    logic                            busy_reg;
    logic                            busy_next;
    logic [rftp_pkg::DIVCNT_W-1:0]   cnt_reg;
    logic [rftp_pkg::DIVCNT_W-1:0]   cnt_next;
    logic [rftp_pkg::FRAMES_W:0]     rem_reg;
    logic [rftp_pkg::SUM_W-1:0]      quo_reg;
    logic [rftp_pkg::FRAMES_W-1:0]   dvs_reg;

    logic [rftp_pkg::FRAMES_W:0]     shifted;
    logic [rftp_pkg::FRAMES_W:0]     diff;
    logic                            ge;

    assign shifted = {rem_reg[rftp_pkg::FRAMES_W-1:0], quo_reg[rftp_pkg::SUM_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = rftp_pkg::DIVCNT_W'(rftp_pkg::SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - rftp_pkg::DIVCNT_W'(1);
            if (cnt_reg == rftp_pkg::DIVCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : shifted;
            quo_reg <= {quo_reg[rftp_pkg::SUM_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = (|quo_reg[rftp_pkg::SUM_W-1:rftp_pkg::TIME_W])
                    ? {rftp_pkg::TIME_W{1'b1}}
                    : quo_reg[rftp_pkg::TIME_W-1:0];

endmodule
